@@ src/mgss_pkg.sv @@
// shared types, constants and a helper function for the gaussian sampler step
package mgss_pkg;

  localparam int unsigned FRAC_BITS      = 16;
  localparam logic [16:0] UNIFORM_LIMIT  = 17'd32767;
  localparam logic [16:0] UNIFORM_LIMIT2 = 17'd65534;
  localparam logic [31:0] LN2_Q32        = 32'd2977044472;
  localparam logic [5:0]  DIV_STEPS      = 6'd33;
  localparam logic [3:0]  LOG_LAST       = 4'd15;
  localparam logic [4:0]  LOG_B_INIT     = 5'd16;
  localparam logic [20:0] NL2_BASE       = 21'd1048576;
  localparam logic [16:0] ONE_Q          = 17'd65536;
  localparam logic [38:0] SQRT_BIT0      = 39'd1 << 38;

  localparam logic [23:0]        SCALE_RST = 24'd131072;
  localparam logic signed [23:0] MEAN_RST  = 24'sd65536;
  localparam logic signed [23:0] START_RST = 24'sd65536;
  localparam logic signed [23:0] POS_RST   = 24'sd65536;
  localparam logic [19:0]        CNT_MAX   = 20'hFFFFF;
  localparam logic signed [44:0] SUM_MAX   = 45'sd8796093022207;
  localparam logic signed [44:0] SUM_MIN   = -45'sd8796093022208;
  localparam logic signed [29:0] P_MAX     = 30'sd8388607;
  localparam logic signed [29:0] P_MIN     = -30'sd8388608;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 112;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_MEAN  = 2'd1,
    REG_START = 2'd2
  } cfg_reg_e;

  typedef enum logic [21:0] {
    ST_IDLE     = 22'h000001,
    ST_SQ_U     = 22'h000002,
    ST_SQ_V     = 22'h000004,
    ST_CHK      = 22'h000008,
    ST_LOG_NORM = 22'h000010,
    ST_LOG_SQ   = 22'h000020,
    ST_LOG_ACC  = 22'h000040,
    ST_LT_MUL   = 22'h000080,
    ST_LT_GET   = 22'h000100,
    ST_DIV_W    = 22'h000200,
    ST_Z2_MUL   = 22'h000400,
    ST_Z2_GET   = 22'h000800,
    ST_SQRT     = 22'h001000,
    ST_STEP_MUL = 22'h002000,
    ST_STEP_GET = 22'h004000,
    ST_DA_MUL   = 22'h008000,
    ST_DB_MUL   = 22'h010000,
    ST_A_GET    = 22'h020000,
    ST_G_MUL    = 22'h040000,
    ST_THR      = 22'h080000,
    ST_UPDATE   = 22'h100000,
    ST_DONE     = 22'h200000
  } state_e;

  // log2 in q.16 by repeated squaring, for constants at elaboration
  function automatic logic [20:0] log2q_const(input int unsigned n);
    longint unsigned x;
    int unsigned     b;
    logic [15:0]     frac;
    b = 0;
    frac = '0;
    for (int k = 0; k < 32; k++) begin
      if ((n >> k) != 0) b = k;
    end
    if (b >= FRAC_BITS) x = longint'(n) >> (b - FRAC_BITS);
    else x = longint'(n) << (FRAC_BITS - b);
    for (int k = 0; k < FRAC_BITS; k++) begin
      x = (x * x) >> FRAC_BITS;
      frac = {frac[14:0], 1'b0};
      if (x >= (longint'(2) << FRAC_BITS)) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    return {5'(b), frac};
  endfunction

  localparam logic [20:0] LOG2_10000 = log2q_const(10000);

endpackage

@@ src/metropolis_gaussian_sampler_step.sv @@
// Gaussian-target random-walk sampler step with a shared multiplier and sequencer
//
// Input stream (s_axis): tuser carries op (0 step, 1 restart), tdata the raw
// uniform pair and the acceptance draw. One item is taken only while the
// block is idle (s_axis_tready high); it then works alone until its result
// is placed in the output register.
// Output stream (m_axis): one result per input item, flags in tuser, chain
// state in tdata. A stalled receiver holds the result; the block keeps
// working on a new item and waits at its end until the register is free.
// Configuration: cfg_valid_i/cfg_ready_o with a register index and data,
// always ready; write only while idle.
// Work per item: restart goes straight to the done state, a pair outside the
// disc ends after the radius check, a step with dice zero runs one log2 and
// any other step two; the work is set by one 33-pass division, the 16-pass log2
// squarings on the multiplier (plus normalising shifts) and a 20-pass square root.
// The next item is taken only after the result is placed in the output register.
// Reset: position 1.0, counts and sum zero, registers at their defaults.
module metropolis_gaussian_sampler_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // u_raw[14:0], v_raw[29:15], dice_raw[43:30]
  input  logic         s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // position, accept_total, reject_total, position_total
  output logic [1:0]   m_axis_tuser,  // accepted, retry
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  mgss_pkg::state_e state_q, state_d;

  logic [23:0]        scale_q;
  logic signed [23:0] mean_q, start_q, pos_q, p_q;
  logic [19:0]        acnt_q, rcnt_q;
  logic signed [43:0] sum_q;

  logic [13:0] dice_q;
  logic        u_neg_q;
  logic [16:0] u_mag_q, v_mag_q, r_q;
  logic [33:0] uu_q;

  logic [32:0] div_num_q;
  logic [16:0] div_rem_q, div_den_q;
  logic [5:0]  div_cnt_q;

  logic [16:0] log_x_q;
  logic [4:0]  log_b_q;
  logic [15:0] log_frac_q;
  logic [3:0]  log_i_q;
  logic        log_dice_q;

  logic [20:0] lterm_q;
  logic [17:0] w_q;
  logic [38:0] sq_n_q, sq_res_q, sq_bit_q;
  logic [48:0] sq1_q;
  logic signed [49:0] a_q;
  logic        g_neg_q, acc_q, retry_q;

  logic [24:0] mul_a;
  logic [31:0] mul_b;
  logic [56:0] prod_q;

  logic        out_vld_q, out_acc_q, out_retry_q;
  logic [23:0] out_pos_q;
  logic [19:0] out_acnt_q, out_rcnt_q;
  logic [43:0] out_sum_q;

  // input decode
  logic        in_fire, can_load;
  logic [14:0] in_u_raw, in_v_raw;
  logic signed [16:0] u_num, v_num;
  logic [14:0] u_nmag, v_nmag;
  logic [15:0] u_dbl, v_dbl;
  logic [16:0] u_map, v_map;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_u_raw = s_axis_tdata[14:0];
  assign in_v_raw = s_axis_tdata[29:15];
  assign u_num  = $signed({1'b0, in_u_raw, 1'b0}) - $signed(mgss_pkg::UNIFORM_LIMIT);
  assign v_num  = $signed({1'b0, in_v_raw, 1'b0}) - $signed(mgss_pkg::UNIFORM_LIMIT);
  assign u_nmag = u_num[16] ? 15'(-u_num) : u_num[14:0];
  assign v_nmag = v_num[16] ? 15'(-v_num) : v_num[14:0];

  // m * 2^16 / limit with 2^16 = 2*limit + 2: twice m plus a carry of 0 to 2
  assign u_dbl = {u_nmag, 1'b0};
  assign v_dbl = {v_nmag, 1'b0};
  assign u_map = {1'b0, u_dbl} + 17'({1'b0, u_dbl} >= mgss_pkg::UNIFORM_LIMIT)
               + 17'({1'b0, u_dbl} >= mgss_pkg::UNIFORM_LIMIT2);
  assign v_map = {1'b0, v_dbl} + 17'({1'b0, v_dbl} >= mgss_pkg::UNIFORM_LIMIT)
               + 17'({1'b0, v_dbl} >= mgss_pkg::UNIFORM_LIMIT2);

  // restoring divider, one quotient bit per cycle
  logic [17:0] div_sh;
  logic        div_ge, div_done;
  logic [16:0] div_rem_nx;
  assign div_sh     = {div_rem_q, div_num_q[32]};
  assign div_ge     = div_sh >= {1'b0, div_den_q};
  assign div_rem_nx = div_ge ? 17'(div_sh - {1'b0, div_den_q}) : div_sh[16:0];
  assign div_done   = div_cnt_q == mgss_pkg::DIV_STEPS;

  // log2 pieces
  logic [17:0] log_sq;
  logic [20:0] log_val, nl2;
  assign log_sq  = prod_q[33:16];
  assign log_val = {log_b_q, log_frac_q};
  assign nl2     = mgss_pkg::NL2_BASE - log_val;

  // radius check
  logic [33:0] s_sum;
  logic [17:0] r_full;
  logic        r_bad;
  assign s_sum  = uu_q + prod_q[33:0];
  assign r_full = s_sum[33:16];
  assign r_bad  = (r_full == '0) || (r_full > {1'b0, mgss_pkg::ONE_Q});

  // root pieces
  logic [38:0] sq_try;
  logic        sq_ge;
  assign sq_try = sq_res_q + sq_bit_q;
  assign sq_ge  = sq_n_q >= sq_try;

  // proposal
  logic [27:0]        step;
  logic signed [29:0] p_wide, p_sat;
  assign step   = prod_q[43:16];
  assign p_wide = 30'(pos_q) + (u_neg_q ? -$signed({2'b0, step}) : $signed({2'b0, step}));
  assign p_sat  = (p_wide > mgss_pkg::P_MAX) ? mgss_pkg::P_MAX :
                  (p_wide < mgss_pkg::P_MIN) ? mgss_pkg::P_MIN : p_wide;

  logic signed [24:0] pd, qd;
  logic [24:0]        pd_mag, qd_mag;
  assign pd     = 25'(p_q) - 25'(mean_q);
  assign qd     = 25'(pos_q) - 25'(mean_q);
  assign pd_mag = pd[24] ? 25'(-pd) : pd;
  assign qd_mag = qd[24] ? 25'(-qd) : qd;

  // log-domain threshold
  logic signed [21:0] g;
  logic [20:0]        g_mag;
  logic [36:0]        rmag;
  logic signed [37:0] rthr;
  logic               acc_thr;
  assign g       = $signed({1'b0, mgss_pkg::LOG2_10000}) - $signed({1'b0, log_val});
  assign g_mag   = g[21] ? 21'(-g) : g[20:0];
  assign rmag    = prod_q[51:15];
  assign rthr    = g_neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  assign acc_thr = a_q < 50'(rthr);

  // state update
  logic signed [23:0] pos_new;
  logic signed [44:0] sum_wide, sum_sat;
  assign pos_new  = acc_q ? p_q : pos_q;
  assign sum_wide = 45'(sum_q) + 45'(pos_new);
  assign sum_sat  = (sum_wide > mgss_pkg::SUM_MAX) ? mgss_pkg::SUM_MAX :
                    (sum_wide < mgss_pkg::SUM_MIN) ? mgss_pkg::SUM_MIN : sum_wide;

  assign can_load = !out_vld_q || m_axis_tready;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      mgss_pkg::ST_SQ_U:     begin mul_a = 25'(u_mag_q); mul_b = 32'(u_mag_q); end
      mgss_pkg::ST_SQ_V:     begin mul_a = 25'(v_mag_q); mul_b = 32'(v_mag_q); end
      mgss_pkg::ST_LOG_SQ:   begin mul_a = 25'(log_x_q); mul_b = 32'(log_x_q); end
      mgss_pkg::ST_LT_MUL:   begin mul_a = 25'(nl2); mul_b = mgss_pkg::LN2_Q32; end
      mgss_pkg::ST_Z2_MUL:   begin mul_a = 25'(w_q); mul_b = 32'(lterm_q); end
      mgss_pkg::ST_STEP_MUL: begin mul_a = 25'(scale_q); mul_b = 32'(sq_res_q[19:0]); end
      mgss_pkg::ST_DA_MUL:   begin mul_a = pd_mag; mul_b = 32'(pd_mag); end
      mgss_pkg::ST_DB_MUL:   begin mul_a = qd_mag; mul_b = 32'(qd_mag); end
      mgss_pkg::ST_G_MUL:    begin mul_a = 25'(g_mag); mul_b = mgss_pkg::LN2_Q32; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mgss_pkg::ST_IDLE:
        if (in_fire) begin
          state_d = (s_axis_tuser == mgss_pkg::OP_RESTART) ? mgss_pkg::ST_DONE
                                                           : mgss_pkg::ST_SQ_U;
        end
      mgss_pkg::ST_SQ_U:      state_d = mgss_pkg::ST_SQ_V;
      mgss_pkg::ST_SQ_V:      state_d = mgss_pkg::ST_CHK;
      mgss_pkg::ST_CHK:       state_d = r_bad ? mgss_pkg::ST_DONE : mgss_pkg::ST_LOG_NORM;
      mgss_pkg::ST_LOG_NORM:  if (log_x_q[16]) state_d = mgss_pkg::ST_LOG_SQ;
      mgss_pkg::ST_LOG_SQ:    state_d = mgss_pkg::ST_LOG_ACC;
      mgss_pkg::ST_LOG_ACC: begin
        if (log_i_q != mgss_pkg::LOG_LAST) state_d = mgss_pkg::ST_LOG_SQ;
        else state_d = log_dice_q ? mgss_pkg::ST_G_MUL : mgss_pkg::ST_LT_MUL;
      end
      mgss_pkg::ST_LT_MUL:    state_d = mgss_pkg::ST_LT_GET;
      mgss_pkg::ST_LT_GET:    state_d = mgss_pkg::ST_DIV_W;
      mgss_pkg::ST_DIV_W:     if (div_done) state_d = mgss_pkg::ST_Z2_MUL;
      mgss_pkg::ST_Z2_MUL:    state_d = mgss_pkg::ST_Z2_GET;
      mgss_pkg::ST_Z2_GET:    state_d = mgss_pkg::ST_SQRT;
      mgss_pkg::ST_SQRT:      if (sq_bit_q == '0) state_d = mgss_pkg::ST_STEP_MUL;
      mgss_pkg::ST_STEP_MUL:  state_d = mgss_pkg::ST_STEP_GET;
      mgss_pkg::ST_STEP_GET:  state_d = mgss_pkg::ST_DA_MUL;
      mgss_pkg::ST_DA_MUL:    state_d = mgss_pkg::ST_DB_MUL;
      mgss_pkg::ST_DB_MUL:    state_d = mgss_pkg::ST_A_GET;
      mgss_pkg::ST_A_GET:
        state_d = (dice_q == '0) ? mgss_pkg::ST_UPDATE : mgss_pkg::ST_LOG_NORM;
      mgss_pkg::ST_G_MUL:     state_d = mgss_pkg::ST_THR;
      mgss_pkg::ST_THR:       state_d = mgss_pkg::ST_UPDATE;
      mgss_pkg::ST_UPDATE:    state_d = mgss_pkg::ST_DONE;
      mgss_pkg::ST_DONE:      if (can_load) state_d = mgss_pkg::ST_IDLE;
      default:                state_d = mgss_pkg::ST_IDLE;
    endcase
  end

  // control state, configuration and chain state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mgss_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
      scale_q   <= mgss_pkg::SCALE_RST;
      mean_q    <= mgss_pkg::MEAN_RST;
      start_q   <= mgss_pkg::START_RST;
      pos_q     <= mgss_pkg::POS_RST;
      acnt_q    <= '0;
      rcnt_q    <= '0;
      sum_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == mgss_pkg::ST_DONE && can_load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          mgss_pkg::REG_SCALE: scale_q <= cfg_data_i;
          mgss_pkg::REG_MEAN:  mean_q  <= $signed(cfg_data_i);
          mgss_pkg::REG_START: start_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      if (in_fire && s_axis_tuser == mgss_pkg::OP_RESTART) begin
        pos_q  <= start_q;
        acnt_q <= '0;
        rcnt_q <= '0;
        sum_q  <= '0;
      end
      if (state_q == mgss_pkg::ST_UPDATE) begin
        pos_q <= pos_new;
        if (acc_q) begin
          if (acnt_q != mgss_pkg::CNT_MAX) acnt_q <= acnt_q + 20'd1;
        end else if (rcnt_q != mgss_pkg::CNT_MAX) begin
          rcnt_q <= rcnt_q + 20'd1;
        end
        sum_q <= sum_sat[43:0];
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= 57'(mul_a) * 57'(mul_b);
    case (state_q)
      mgss_pkg::ST_IDLE: begin
        dice_q  <= s_axis_tdata[43:30];
        u_neg_q <= u_num[16];
        u_mag_q <= u_map;
        v_mag_q <= v_map;
        acc_q   <= 1'b0;
        retry_q <= 1'b0;
      end
      mgss_pkg::ST_DIV_W: begin
        if (!div_done) begin
          div_num_q <= {div_num_q[31:0], div_ge};
          div_rem_q <= div_rem_nx;
          div_cnt_q <= div_cnt_q + 6'd1;
        end else begin
          w_q <= div_num_q[17:0];
        end
      end
      mgss_pkg::ST_SQ_V: uu_q <= prod_q[33:0];
      mgss_pkg::ST_CHK: begin
        retry_q    <= r_bad;
        r_q        <= r_full[16:0];
        log_x_q    <= r_full[16:0];
        log_b_q    <= mgss_pkg::LOG_B_INIT;
        log_frac_q <= '0;
        log_i_q    <= '0;
        log_dice_q <= 1'b0;
      end
      mgss_pkg::ST_LOG_NORM: begin
        if (!log_x_q[16]) begin
          log_x_q <= {log_x_q[15:0], 1'b0};
          log_b_q <= log_b_q - 5'd1;
        end
      end
      mgss_pkg::ST_LOG_ACC: begin
        log_x_q    <= log_sq[17] ? log_sq[17:1] : log_sq[16:0];
        log_frac_q <= {log_frac_q[14:0], log_sq[17]};
        log_i_q    <= log_i_q + 4'd1;
      end
      mgss_pkg::ST_LT_GET: begin
        lterm_q   <= prod_q[51:31];
        div_num_q <= {1'b0, uu_q[31:0]} | {uu_q[32], 32'b0};
        div_den_q <= r_q;
        div_rem_q <= '0;
        div_cnt_q <= '0;
      end
      mgss_pkg::ST_Z2_GET: begin
        sq_n_q   <= {prod_q[38:16], 16'b0};
        sq_res_q <= '0;
        sq_bit_q <= mgss_pkg::SQRT_BIT0;
      end
      mgss_pkg::ST_SQRT: begin
        if (sq_bit_q != '0) begin
          if (sq_ge) begin
            sq_n_q   <= sq_n_q - sq_try;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
        end
      end
      mgss_pkg::ST_STEP_GET: p_q <= p_sat[23:0];
      mgss_pkg::ST_DB_MUL:   sq1_q <= prod_q[48:0];
      mgss_pkg::ST_A_GET: begin
        a_q        <= $signed({1'b0, sq1_q}) - $signed({1'b0, prod_q[48:0]});
        acc_q      <= dice_q == '0;
        log_x_q    <= {3'b0, dice_q};
        log_b_q    <= mgss_pkg::LOG_B_INIT;
        log_frac_q <= '0;
        log_i_q    <= '0;
        log_dice_q <= 1'b1;
      end
      mgss_pkg::ST_G_MUL: g_neg_q <= g[21];
      mgss_pkg::ST_THR:   acc_q <= acc_thr;
      mgss_pkg::ST_DONE: begin
        if (can_load) begin
          out_acc_q   <= acc_q;
          out_retry_q <= retry_q;
          out_pos_q   <= pos_q;
          out_acnt_q  <= acnt_q;
          out_rcnt_q  <= rcnt_q;
          out_sum_q   <= sum_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = state_q == mgss_pkg::ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = {out_retry_q, out_acc_q};
  assign m_axis_tdata  = {4'b0, out_sum_q, out_rcnt_q, out_acnt_q, out_pos_q};

endmodule

@@ src/mgss_checker.sv @@
// port-level checks for the sampler step, bound to the top level
module mgss_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [mgss_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // a result is never both accepted and a retry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("accepted and retry both set");

  // the block is busy right after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after an item was taken");

endmodule

bind metropolis_gaussian_sampler_step mgss_checker u_mgss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
